// ===== src/firmware_chunk_request_server_assert.svh =====
// Assertion macros shared by the firmware chunk request server modules
`ifndef FIRMWARE_CHUNK_REQUEST_SERVER_ASSERT_SVH
`define FIRMWARE_CHUNK_REQUEST_SERVER_ASSERT_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FCRS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FCRS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/fcrs_pkg.sv =====
// Types, constants and the CRC-8 step shared by the firmware chunk request server
package fcrs_pkg;

    localparam int COUNT_BITS_DEF = 16;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int IMG_W      = 24;
    localparam int MS_W       = 32;

    localparam logic [7:0] HDR_START = 8'hAB;
    localparam logic [7:0] HDR_DATA  = 8'hA7;
    localparam logic [7:0] HDR_PAD   = 8'h00;
    localparam logic [7:0] CRC_INIT  = 8'hFF;
    localparam logic [7:0] CRC_POLY  = 8'h07;

    localparam logic [3:0] LEN_START = 4'd5;
    localparam logic [3:0] LEN_DATA  = 4'd10;

    // header plus payload; the CRC byte itself is never stored
    localparam int FRAME_DEPTH = 9;

    localparam logic [MS_W-1:0] QUIET_RST       = 32'd50;
    localparam logic [MS_W-1:0] START_TO_RST    = 32'd2000;
    localparam logic [MS_W-1:0] OVERALL_TO_RST  = 32'd30000;

    typedef enum logic [2:0] {
        EV_NONE      = 3'd0,
        EV_START_ACK = 3'd1,
        EV_EMPTY_ACK = 3'd2,
        EV_CHUNK     = 3'd3,
        EV_CRC_DROP  = 3'd4
    } event_t;

    typedef enum logic [2:0] {
        ST_RUNNING    = 3'd0,
        ST_OK         = 3'd1,
        ST_NO_IMAGE   = 3'd2,
        ST_NO_START   = 3'd3,
        ST_BAD_HEADER = 3'd4,
        ST_BAD_OFFSET = 3'd5,
        ST_STALLED    = 3'd6
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_LENGTH = 3'd0,
        REG_ACK_CODE     = 3'd1,
        REG_QUIET        = 3'd2,
        REG_START_TO     = 3'd3,
        REG_OVERALL_TO   = 3'd4
    } cfg_reg_t;

    // timer requests from the frame logic
    typedef struct packed {
        logic tick;
        logic rx;
    } tmr_ctl_t;

    // timeout decision for a tick transaction
    typedef struct packed {
        logic    expired;
        status_t code;
    } tmr_verdict_t;

    // CRC-8, poly 0x07, MSB first, one byte
    function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
        logic [7:0] c;
        c = crc ^ b;
        for (int i = 0; i < 8; i++) begin
            c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
        end
        return c;
    endfunction

endpackage

// ===== src/firmware_chunk_request_server.sv =====
// Top level of the firmware chunk request server: framing, CRC, request checks, result register
//
//  channel   | direction | handshake             | payload
//  ----------+-----------+-----------------------+---------------------------------------------
//  s_axis    | in        | s_axis_tvalid/tready  | tdata: rx_byte; tuser: mode
//  m_axis    | out       | m_axis_tvalid/tready  | tdata: status..start_count; tuser: event_res
//  cfg       | in        | cfg_valid/cfg_ready   | cfg_index, cfg_data (register write)
//
//  One registered result per input transaction; one transaction per cycle while no result sits unread.
//  The per-transaction path is the byte CRC step, the 33-bit offset+length add and its
//  compares against image_length; all state updates in the accepting cycle.
//  s_axis_tready drops only while a result sits unread in the output register.
//  cfg_ready is always high. rst_n is asynchronous, active low; no clearing pass is needed.
`include "firmware_chunk_request_server_assert.svh"

module firmware_chunk_request_server
#(
    parameter int COUNT_BITS = fcrs_pkg::COUNT_BITS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,

    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] rx_byte
    input  logic [0:0]                        s_axis_tuser,   // [0] mode

    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [2:0] status, [26:3] chunk_offset, [42:27] chunk_length, [58:43] chip_id,
    // [66:59] loader_version, [82:67] card fault word, [90:83] ack_check,
    // [106:91] retransmit_count, [122:107] crc_error_count, [138:123] chunk_count,
    // [154:139] start_count, [159:155] zero
    output logic [159:0]                      m_axis_tdata,
    output logic [2:0]                        m_axis_tuser,   // [2:0] event_res

    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fcrs_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [fcrs_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int IW = fcrs_pkg::IMG_W;
    localparam int LEN_LSB = 27;
    localparam int LEN_MSB = 42;

    // ---------------- configuration registers ----------------
    logic [IW-1:0]              image_length_reg;
    logic [7:0]                 ack_code_reg;
    logic [fcrs_pkg::MS_W-1:0]  quiet_ms_reg;
    logic [fcrs_pkg::MS_W-1:0]  start_to_reg;
    logic [fcrs_pkg::MS_W-1:0]  overall_to_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_length_reg <= '0;
            ack_code_reg     <= '0;
            quiet_ms_reg     <= fcrs_pkg::QUIET_RST;
            start_to_reg     <= fcrs_pkg::START_TO_RST;
            overall_to_reg   <= fcrs_pkg::OVERALL_TO_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                fcrs_pkg::REG_IMAGE_LENGTH: image_length_reg <= cfg_data[IW-1:0];
                fcrs_pkg::REG_ACK_CODE:     ack_code_reg     <= cfg_data[7:0];
                fcrs_pkg::REG_QUIET:        quiet_ms_reg     <= cfg_data;
                fcrs_pkg::REG_START_TO:     start_to_reg     <= cfg_data;
                fcrs_pkg::REG_OVERALL_TO:   overall_to_reg   <= cfg_data;
                default: ;  // unused indexes are ignored
            endcase
        end
    end

    // ---------------- run state ----------------
    logic [7:0]             frame_bytes_reg [fcrs_pkg::FRAME_DEPTH];
    logic [3:0]             bytes_have_reg,   bytes_have_next;
    logic [3:0]             bytes_need_reg,   bytes_need_next;
    logic [7:0]             crc_reg,          crc_next;
    logic                   all_served_reg,   all_served_next;
    logic                   have_prev_reg,    have_prev_next;
    logic [IW-1:0]          prev_off_reg,     prev_off_next;
    logic [IW-1:0]          highest_end_reg,  highest_end_next;
    fcrs_pkg::status_t      run_status_reg,   run_status_next;
    logic [23:0]            start_info_reg,   start_info_next;
    logic [15:0]            card_err_reg,     card_err_next;
    logic [COUNT_BITS-1:0]  retx_cnt_reg,     retx_cnt_next;
    logic [COUNT_BITS-1:0]  crc_cnt_reg,      crc_cnt_next;
    logic [COUNT_BITS-1:0]  chunk_cnt_reg,    chunk_cnt_next;
    logic [COUNT_BITS-1:0]  start_cnt_reg,    start_cnt_next;

    logic                   frame_we;
    logic [3:0]             frame_waddr;

    // output register
    logic                   m_valid_reg;
    logic [159:0]           m_data_reg,  m_data_next;
    logic [2:0]             m_user_reg;

    logic                   s_fire;
    fcrs_pkg::event_t       ev;
    logic [IW-1:0]          out_off;
    logic [15:0]            out_len;
    logic [7:0]             ack_check;

    fcrs_pkg::tmr_ctl_t     tmr_ctl;
    fcrs_pkg::tmr_verdict_t tmr_verdict;

    // decoded data request fields (little endian)
    logic [15:0]            req_len;
    logic [31:0]            req_off;
    logic [15:0]            req_cerr;
    logic [32:0]            req_end;
    logic                   req_outside;

    assign s_axis_tready = !m_valid_reg || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign req_len  = {frame_bytes_reg[2], frame_bytes_reg[1]};
    assign req_off  = {frame_bytes_reg[6], frame_bytes_reg[5],
                       frame_bytes_reg[4], frame_bytes_reg[3]};
    assign req_cerr = {frame_bytes_reg[8], frame_bytes_reg[7]};
    assign req_end  = {1'b0, req_off} + {17'd0, req_len};
    assign req_outside = (req_off > {8'd0, image_length_reg}) ||
                         (req_end > {9'd0, image_length_reg});

    assign ack_check = fcrs_pkg::crc8_step(fcrs_pkg::CRC_INIT, ack_code_reg);

    fcrs_timer u_timer
    (
        .clk                (clk),
        .rst_n              (rst_n),
        .ctl                (tmr_ctl),
        .all_served         (all_served_reg),
        .start_seen         (start_cnt_reg != '0),
        .quiet_ms           (quiet_ms_reg),
        .start_timeout_ms   (start_to_reg),
        .overall_timeout_ms (overall_to_reg),
        .verdict            (tmr_verdict)
    );

    // ---------------- per-transaction logic ----------------
    always_comb
    begin
        bytes_have_next  = bytes_have_reg;
        bytes_need_next  = bytes_need_reg;
        crc_next         = crc_reg;
        all_served_next  = all_served_reg;
        have_prev_next   = have_prev_reg;
        prev_off_next    = prev_off_reg;
        highest_end_next = highest_end_reg;
        run_status_next  = run_status_reg;
        start_info_next  = start_info_reg;
        card_err_next    = card_err_reg;
        retx_cnt_next    = retx_cnt_reg;
        crc_cnt_next     = crc_cnt_reg;
        chunk_cnt_next   = chunk_cnt_reg;
        start_cnt_next   = start_cnt_reg;
        frame_we         = 1'b0;
        frame_waddr      = bytes_have_reg;
        ev               = fcrs_pkg::EV_NONE;
        out_off          = '0;
        out_len          = '0;
        tmr_ctl          = '0;

        // an ended run ignores everything
        if (s_fire && (run_status_reg == fcrs_pkg::ST_RUNNING))
        begin
            priority if (image_length_reg == '0)
            begin
                run_status_next = fcrs_pkg::ST_NO_IMAGE;
            end
            else if (s_axis_tuser[0])
            begin
                tmr_ctl.tick = 1'b1;
                if (tmr_verdict.expired)
                begin
                    run_status_next = tmr_verdict.code;
                end
            end
            else
            begin
                tmr_ctl.rx = 1'b1;
                priority if (bytes_need_reg == 4'd0)
                begin
                    // header slot: padding zeros skipped, unknown header ends the run
                    priority if (s_axis_tdata == fcrs_pkg::HDR_START ||
                                 s_axis_tdata == fcrs_pkg::HDR_DATA)
                    begin
                        bytes_need_next = (s_axis_tdata == fcrs_pkg::HDR_START) ?
                                          fcrs_pkg::LEN_START : fcrs_pkg::LEN_DATA;
                        bytes_have_next = 4'd1;
                        frame_we        = 1'b1;
                        frame_waddr     = 4'd0;
                        crc_next        = fcrs_pkg::crc8_step(fcrs_pkg::CRC_INIT,
                                                              s_axis_tdata);
                    end
                    else if (s_axis_tdata != fcrs_pkg::HDR_PAD)
                    begin
                        run_status_next = fcrs_pkg::ST_BAD_HEADER;
                    end
                    else
                    begin
                        run_status_next = run_status_reg;
                    end
                end
                else if (bytes_have_reg < bytes_need_reg - 4'd1)
                begin
                    frame_we        = 1'b1;
                    bytes_have_next = bytes_have_reg + 4'd1;
                    crc_next        = fcrs_pkg::crc8_step(crc_reg, s_axis_tdata);
                end
                else
                begin
                    // CRC byte closes the frame
                    bytes_have_next = 4'd0;
                    bytes_need_next = 4'd0;
                    crc_next        = fcrs_pkg::CRC_INIT;
                    priority if (crc_reg != s_axis_tdata)
                    begin
                        ev = fcrs_pkg::EV_CRC_DROP;
                        if (crc_cnt_reg != '1)
                        begin
                            crc_cnt_next = crc_cnt_reg + COUNT_BITS'(1);
                        end
                    end
                    else if (frame_bytes_reg[0] == fcrs_pkg::HDR_START)
                    begin
                        ev              = fcrs_pkg::EV_START_ACK;
                        start_info_next = {frame_bytes_reg[3], frame_bytes_reg[2],
                                           frame_bytes_reg[1]};
                        if (start_cnt_reg != '1)
                        begin
                            start_cnt_next = start_cnt_reg + COUNT_BITS'(1);
                        end
                    end
                    else
                    begin
                        // card error word is kept even if the offset check fails
                        if (req_cerr != '0)
                        begin
                            card_err_next = req_cerr;
                        end
                        priority if (req_len == '0)
                        begin
                            ev = fcrs_pkg::EV_EMPTY_ACK;
                        end
                        else if (req_outside)
                        begin
                            run_status_next = fcrs_pkg::ST_BAD_OFFSET;
                        end
                        else
                        begin
                            // inside the image, so offset and end fit in IW bits
                            ev = fcrs_pkg::EV_CHUNK;
                            if (have_prev_reg && (req_off[IW-1:0] == prev_off_reg))
                            begin
                                if (retx_cnt_reg != '1)
                                begin
                                    retx_cnt_next = retx_cnt_reg + COUNT_BITS'(1);
                                end
                            end
                            prev_off_next  = req_off[IW-1:0];
                            have_prev_next = 1'b1;
                            if (chunk_cnt_reg != '1)
                            begin
                                chunk_cnt_next = chunk_cnt_reg + COUNT_BITS'(1);
                            end
                            if (req_end[IW-1:0] > highest_end_reg)
                            begin
                                highest_end_next = req_end[IW-1:0];
                            end
                            if (highest_end_next >= image_length_reg)
                            begin
                                all_served_next = 1'b1;
                            end
                            out_off = req_off[IW-1:0];
                            out_len = req_len;
                        end
                    end
                end
            end
        end
    end

    // result word, built from the post-transaction state
    assign m_data_next = {5'd0,
                          16'(start_cnt_next),
                          16'(chunk_cnt_next),
                          16'(crc_cnt_next),
                          16'(retx_cnt_next),
                          ack_check,
                          card_err_next,
                          start_info_next[23:16],
                          start_info_next[15:0],
                          out_len,
                          out_off,
                          run_status_next};

    // frame store: written before read, no reset
    always_ff @(posedge clk)
    begin
        if (frame_we)
        begin
            frame_bytes_reg[frame_waddr] <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_have_reg  <= '0;
            bytes_need_reg  <= '0;
            crc_reg         <= fcrs_pkg::CRC_INIT;
            all_served_reg  <= 1'b0;
            have_prev_reg   <= 1'b0;
            prev_off_reg    <= '0;
            highest_end_reg <= '0;
            run_status_reg  <= fcrs_pkg::ST_RUNNING;
            start_info_reg  <= '0;
            card_err_reg    <= '0;
            retx_cnt_reg    <= '0;
            crc_cnt_reg     <= '0;
            chunk_cnt_reg   <= '0;
            start_cnt_reg   <= '0;
        end
        else
        begin
            bytes_have_reg  <= bytes_have_next;
            bytes_need_reg  <= bytes_need_next;
            crc_reg         <= crc_next;
            all_served_reg  <= all_served_next;
            have_prev_reg   <= have_prev_next;
            prev_off_reg    <= prev_off_next;
            highest_end_reg <= highest_end_next;
            run_status_reg  <= run_status_next;
            start_info_reg  <= start_info_next;
            card_err_reg    <= card_err_next;
            retx_cnt_reg    <= retx_cnt_next;
            crc_cnt_reg     <= crc_cnt_next;
            chunk_cnt_reg   <= chunk_cnt_next;
            start_cnt_reg   <= start_cnt_next;
        end
    end

    // output register: loads on every accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (s_fire)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            m_data_reg <= m_data_next;
            m_user_reg <= ev;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

    `FCRS_ASSERT_NEXT(a_status_sticky, run_status_reg != fcrs_pkg::ST_RUNNING,
        run_status_reg == $past(run_status_reg), "status left a final value")
    `FCRS_ASSERT_NOW(a_frame_fill, 1'b1,
        ((bytes_need_reg == 4'd0) == (bytes_have_reg == 4'd0)) &&
        (bytes_have_reg <= bytes_need_reg), "frame fill count out of step")
    `FCRS_ASSERT_NOW(a_chunk_nonempty, m_valid_reg && (m_user_reg == fcrs_pkg::EV_CHUNK),
        m_data_reg[LEN_MSB:LEN_LSB] != 16'd0, "chunk served with zero length")

endmodule

// ===== src/fcrs_timer.sv =====
// Millisecond counters and quiet / start / overall timeout decision
`include "firmware_chunk_request_server_assert.svh"

module fcrs_timer
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  fcrs_pkg::tmr_ctl_t          ctl,
    input  logic                        all_served,
    input  logic                        start_seen,
    input  logic [fcrs_pkg::MS_W-1:0]   quiet_ms,
    input  logic [fcrs_pkg::MS_W-1:0]   start_timeout_ms,
    input  logic [fcrs_pkg::MS_W-1:0]   overall_timeout_ms,
    output fcrs_pkg::tmr_verdict_t      verdict
);

    logic [fcrs_pkg::MS_W-1:0] elapsed_reg;
    logic [fcrs_pkg::MS_W-1:0] elapsed_next;
    logic [fcrs_pkg::MS_W-1:0] since_rx_reg;
    logic [fcrs_pkg::MS_W-1:0] since_rx_next;
    logic [fcrs_pkg::MS_W-1:0] elapsed_inc;
    logic [fcrs_pkg::MS_W-1:0] since_rx_inc;

    // saturating increments
    assign elapsed_inc  = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 32'd1;
    assign since_rx_inc = (since_rx_reg == '1) ? since_rx_reg : since_rx_reg + 32'd1;

    always_comb
    begin
        verdict.expired = 1'b1;
        verdict.code    = fcrs_pkg::ST_RUNNING;
        priority if (all_served && (since_rx_inc >= quiet_ms))
        begin
            verdict.code = fcrs_pkg::ST_OK;
        end
        else if (!start_seen && (elapsed_inc >= start_timeout_ms))
        begin
            verdict.code = fcrs_pkg::ST_NO_START;
        end
        else if (elapsed_inc >= overall_timeout_ms)
        begin
            verdict.code = start_seen ? fcrs_pkg::ST_STALLED : fcrs_pkg::ST_NO_START;
        end
        else
        begin
            verdict.expired = 1'b0;
        end
    end

    always_comb
    begin
        elapsed_next  = elapsed_reg;
        since_rx_next = since_rx_reg;
        if (ctl.tick)
        begin
            elapsed_next  = elapsed_inc;
            since_rx_next = since_rx_inc;
        end
        else if (ctl.rx)
        begin
            since_rx_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elapsed_reg  <= '0;
            since_rx_reg <= '0;
        end
        else
        begin
            elapsed_reg  <= elapsed_next;
            since_rx_reg <= since_rx_next;
        end
    end

    `FCRS_ASSERT_NEXT(a_elapsed_monotonic, 1'b1, elapsed_reg >= $past(elapsed_reg), "elapsed time went backwards")
    `FCRS_ASSERT_NOW(a_since_le_elapsed, 1'b1, since_rx_reg <= elapsed_reg, "quiet time exceeds elapsed time")

endmodule
